FILE: rtl/core/tile_pixel_palette_decode_macros.svh
// assertion macros for the tile pixel palette decoder checker
// expects clk and rst_n in the scope where a macro is used
`ifndef TILE_PIXEL_PALETTE_DECODE_MACROS_SVH
`define TILE_PIXEL_PALETTE_DECODE_MACROS_SVH

// same-cycle implication, disabled during reset
`define TPD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpd check failed");

// next-cycle implication, disabled during reset
`define TPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpd check failed");

`endif

FILE: rtl/core/tpd_pkg.sv
// shared types, constants and helpers of the tile pixel palette decoder
// no dependencies
`default_nettype none

package tpd_pkg;

    typedef enum logic [2:0] {
        CMD_BG_PAL_WR  = 3'd0,
        CMD_OBJ_PAL_WR = 3'd1,
        CMD_GFX_WR     = 3'd2,
        CMD_BG_PIXEL   = 3'd3,
        CMD_OBJ_PIXEL  = 3'd4
    } cmd_t;

    localparam logic [1:0] ADDR_BG_256COLOR = 2'd0;

    // raw graphics address before the wrap, widest case is sprite base plus offset
    localparam int RAW_W = 17;

    typedef struct packed {
        cmd_t        cmd;
        logic [7:0]  pal_index;
        logic [14:0] wdata;
        logic        nib_hi;
        logic [3:0]  bank;
        logic        bg8;
    } item_t;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tile_pixel_palette_decode.sv
// top level of the tile pixel palette decoder
// depends on tpd_pkg and tpd_ram
`default_nettype none

// Takes one command word per clock: busy is always low, so every cycle with start
// high accepts a word. Pixel commands return one RGBA word on red, green, blue and
// alpha with done high for one cycle; results leave in command order and the
// receiver cannot stall them. Write commands return nothing and take effect in
// command order with respect to every pixel. Each pixel passes through three stages
// that form and wrap the graphics address modulo GFX_BYTES, one read of the
// graphics memory, one read of a palette memory and the output register. All three
// stores power up undefined and need no clearing pass; read only entries that have
// been written.
module tile_pixel_palette_decode #(
    parameter int GFX_BYTES = 32768
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  command,
    input  wire logic [14:0] gfx_address,
    input  wire logic [7:0]  palette_index,
    input  wire logic [14:0] write_data,
    input  wire logic [15:0] tile_entry,
    input  wire logic [5:0]  pixel_x,
    input  wire logic [5:0]  pixel_y,
    input  wire logic [3:0]  width_tiles,
    input  wire logic [3:0]  sprite_palette,
    output logic             done,
    output logic      [7:0]  red,
    output logic      [7:0]  green,
    output logic      [7:0]  blue,
    output logic      [7:0]  alpha
);

    import tpd_pkg::*;

    localparam int AW     = $clog2(GFX_BYTES);
    localparam int RCP_W  = 34 - AW;
    localparam int PROD_W = RAW_W + RCP_W;
    localparam int Q_W    = RAW_W - AW + 1;
    localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << 32) / GFX_BYTES);
    localparam logic [RAW_W-1:0] GFX_SIZE = RAW_W'(GFX_BYTES);

    // configuration
    logic bg256_reg;
    logic cfg_wr;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_BG_256COLOR) ? {31'd0, bg256_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg256_reg <= 1'b0;
        end
        else if (cfg_wr && paddr == ADDR_BG_256COLOR)
        begin
            bg256_reg <= pwdata[0];
        end
    end

    assign busy = 1'b0;

    // accept stage: decode and raw address
    logic             s1_vld_next;
    item_t            s1_item_next;
    logic [RAW_W-1:0] s1_raw_next;
    logic [2:0]       col;
    logic [2:0]       row;
    logic [6:0]       spr_mul;
    logic [7:0]       spr_tile;

    assign col      = tile_entry[10] ? ~pixel_x[2:0] : pixel_x[2:0];
    assign row      = tile_entry[11] ? ~pixel_y[2:0] : pixel_y[2:0];
    assign spr_mul  = 7'(pixel_y[5:3]) * 7'(width_tiles);
    assign spr_tile = {1'b0, spr_mul} + 8'(pixel_x[5:3]);

    always_comb
    begin
        s1_vld_next            = start && !busy;
        s1_item_next.cmd       = CMD_BG_PAL_WR;
        s1_item_next.pal_index = palette_index;
        s1_item_next.wdata     = write_data;
        s1_item_next.nib_hi    = 1'b0;
        s1_item_next.bank      = tile_entry[15:12];
        s1_item_next.bg8       = bg256_reg;
        s1_raw_next            = RAW_W'(gfx_address);
        case (command)
            CMD_BG_PAL_WR:
            begin
                s1_item_next.cmd = CMD_BG_PAL_WR;
            end
            CMD_OBJ_PAL_WR:
            begin
                s1_item_next.cmd = CMD_OBJ_PAL_WR;
            end
            CMD_GFX_WR:
            begin
                s1_item_next.cmd = CMD_GFX_WR;
            end
            CMD_BG_PIXEL:
            begin
                s1_item_next.cmd = CMD_BG_PIXEL;
                if (bg256_reg)
                begin
                    s1_raw_next = RAW_W'({tile_entry[7:0], pixel_y[2:0], pixel_x[2:0]});
                end
                else
                begin
                    s1_raw_next         = RAW_W'({tile_entry[9:0], row, col[2:1]});
                    s1_item_next.nib_hi = col[0];
                end
            end
            CMD_OBJ_PIXEL:
            begin
                s1_item_next.cmd    = CMD_OBJ_PIXEL;
                s1_item_next.bank   = sprite_palette;
                s1_item_next.nib_hi = pixel_x[0];
                s1_raw_next = RAW_W'(gfx_address)
                            + RAW_W'({spr_tile, pixel_y[2:0], pixel_x[2:1]});
            end
            default:
            begin
                s1_vld_next = 1'b0;
            end
        endcase
    end

    // address wrap pipeline: quotient estimate, back-multiply, correct
    logic             s1_vld_reg;
    logic             s2_vld_reg;
    logic             s3_vld_reg;
    logic             s4_vld_reg;
    item_t            s1_item_reg;
    item_t            s2_item_reg;
    item_t            s3_item_reg;
    item_t            s4_item_reg;
    logic [RAW_W-1:0] s1_raw_reg;
    logic [RAW_W-1:0] s2_raw_reg;
    logic [RAW_W-1:0] s3_raw_reg;
    logic [Q_W-1:0]   s2_q_reg;
    logic [RAW_W-1:0] s3_qg_reg;
    logic [PROD_W-1:0] prod;
    logic [Q_W-1:0]   s2_q_next;
    logic [RAW_W-1:0] s3_qg_next;
    logic [RAW_W-1:0] diff;
    logic [RAW_W-1:0] wrapped;

    assign prod       = PROD_W'(s1_raw_reg) * PROD_W'(RECIP);
    assign s2_q_next  = prod[32 +: Q_W];
    assign s3_qg_next = RAW_W'(s2_q_reg) * GFX_SIZE;
    assign diff       = s3_raw_reg - s3_qg_reg;
    assign wrapped    = (diff >= GFX_SIZE) ? diff - GFX_SIZE : diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
        s1_raw_reg  <= s1_raw_next;
        s2_item_reg <= s1_item_reg;
        s2_raw_reg  <= s1_raw_reg;
        s2_q_reg    <= s2_q_next;
        s3_item_reg <= s2_item_reg;
        s3_raw_reg  <= s2_raw_reg;
        s3_qg_reg   <= s3_qg_next;
        s4_item_reg <= s3_item_reg;
    end

    // graphics memory
    logic       gfx_we;
    logic [7:0] gfx_rdata;

    assign gfx_we = s3_vld_reg && s3_item_reg.cmd == CMD_GFX_WR;

    tpd_ram #(
        .WIDTH (8),
        .DEPTH (GFX_BYTES)
    ) u_gfx_ram (
        .clk   (clk),
        .we    (gfx_we),
        .waddr (wrapped[AW-1:0]),
        .wdata (s3_item_reg.wdata[7:0]),
        .raddr (wrapped[AW-1:0]),
        .rdata (gfx_rdata)
    );

    // palette lookup
    logic [3:0]  nib;
    logic        use_byte;
    logic [7:0]  pal_raddr;
    logic        s5_vld_next;
    logic        s5_zero_next;
    logic        bg_pal_we;
    logic        obj_pal_we;
    logic [14:0] bg_rdata;
    logic [14:0] obj_rdata;

    assign nib          = s4_item_reg.nib_hi ? gfx_rdata[7:4] : gfx_rdata[3:0];
    assign use_byte     = s4_item_reg.cmd == CMD_BG_PIXEL && s4_item_reg.bg8;
    assign pal_raddr    = use_byte ? gfx_rdata : {s4_item_reg.bank, nib};
    assign s5_zero_next = use_byte ? (gfx_rdata == 8'd0) : (nib == 4'd0);
    assign s5_vld_next  = s4_vld_reg && (s4_item_reg.cmd == CMD_BG_PIXEL
                                      || s4_item_reg.cmd == CMD_OBJ_PIXEL);
    assign bg_pal_we    = s4_vld_reg && s4_item_reg.cmd == CMD_BG_PAL_WR;
    assign obj_pal_we   = s4_vld_reg && s4_item_reg.cmd == CMD_OBJ_PAL_WR;

    tpd_ram #(
        .WIDTH (15),
        .DEPTH (256)
    ) u_bg_pal_ram (
        .clk   (clk),
        .we    (bg_pal_we),
        .waddr (s4_item_reg.pal_index),
        .wdata (s4_item_reg.wdata),
        .raddr (pal_raddr),
        .rdata (bg_rdata)
    );

    tpd_ram #(
        .WIDTH (15),
        .DEPTH (256)
    ) u_obj_pal_ram (
        .clk   (clk),
        .we    (obj_pal_we),
        .waddr (s4_item_reg.pal_index),
        .wdata (s4_item_reg.wdata),
        .raddr (pal_raddr),
        .rdata (obj_rdata)
    );

    // color expansion and output word
    logic        s5_vld_reg;
    logic        s5_obj_reg;
    logic        s5_zero_reg;
    logic        done_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;
    logic [7:0]  alpha_reg;
    logic [14:0] color;

    assign color = s5_obj_reg ? obj_rdata : bg_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s5_vld_reg <= s5_vld_next;
            done_reg   <= s5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s5_obj_reg  <= s4_item_reg.cmd == CMD_OBJ_PIXEL;
        s5_zero_reg <= s5_zero_next;
        red_reg     <= widen5(color[4:0]);
        green_reg   <= widen5(color[9:5]);
        blue_reg    <= widen5(color[14:10]);
        alpha_reg   <= s5_zero_reg ? 8'd0 : 8'd255;
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;
    assign alpha = alpha_reg;

endmodule

`default_nettype wire

FILE: rtl/core/tpd_ram.sv
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
`default_nettype none

module tpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/tpd_checker.sv
// port-level checker for the tile pixel palette decoder, bound to the top level
// depends on tpd_pkg and tile_pixel_palette_decode_macros.svh
`default_nettype none

`include "tile_pixel_palette_decode_macros.svh"

module tpd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [1:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata,
    input wire logic        pready,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [2:0]  command,
    input wire logic        done,
    input wire logic [7:0]  red,
    input wire logic [7:0]  green,
    input wire logic [7:0]  blue,
    input wire logic [7:0]  alpha
);

    import tpd_pkg::*;

    logic       pix_acc;
    logic       cfg_wr;
    logic       word_ok;
    logic       other_addr;
    logic [2:0] warm_cnt_reg;

    assign pix_acc = start && !busy
                  && (command == CMD_BG_PIXEL || command == CMD_OBJ_PIXEL);
    assign cfg_wr  = psel && penable && pwrite && pready && paddr == ADDR_BG_256COLOR;
    assign word_ok = red[2:0] == red[7:5] && green[2:0] == green[7:5]
                  && blue[2:0] == blue[7:5] && (alpha == 8'd0 || alpha == 8'd255);
    assign other_addr = paddr != ADDR_BG_256COLOR;

    // cycles since reset release, saturating
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_cnt_reg <= 3'd0;
        end
        else if (warm_cnt_reg != 3'd7)
        begin
            warm_cnt_reg <= warm_cnt_reg + 3'd1;
        end
    end

    `TPD_ASSERT_NOW(a_pixel_gives_word, warm_cnt_reg >= 3'd6 && $past(pix_acc, 6), done)
    `TPD_ASSERT_NOW(a_word_from_pixel, done, $past(pix_acc, 6))
    `TPD_ASSERT_NOW(a_word_widened, done, word_ok)
    `TPD_ASSERT_NEXT(a_cfg_readback, cfg_wr, prdata == {31'd0, $past(pwdata[0])} || other_addr)

endmodule

bind tile_pixel_palette_decode tpd_checker u_tpd_checker (.*);

`default_nettype wire
